>>> hdl/ttr_pkg.sv
// shared types, constants and helpers for the tcp timestamp-to-address rewriter
// used by ttr_front, ttr_queue, ttr_back and the top level
package ttr_pkg;

  localparam int HEADER_WORDS     = 32;
  localparam int HW_AW            = $clog2(HEADER_WORDS);
  localparam int PW               = HW_AW + 3;          // byte position width
  localparam int AVW              = PW + 1;             // byte count width
  localparam int MAX_OPTION_STEPS = 10;
  localparam int SW               = $clog2(MAX_OPTION_STEPS + 1);
  localparam int Q_DEPTH          = 4;
  localparam int Q_AW             = $clog2(Q_DEPTH);

  localparam logic [15:0] VLAN_TPID  = 16'h8100;
  localparam logic [7:0]  PROTO_TCP  = 8'd6;
  localparam logic [7:0]  OPT_EOL    = 8'd0;
  localparam logic [7:0]  OPT_NOP    = 8'd1;
  localparam logic [7:0]  OPT_TS     = 8'd8;
  localparam logic [7:0]  TS_LEN     = 8'd10;
  localparam logic [7:0]  NEW_LEN    = 8'd8;
  localparam logic [7:0]  SYN_ACK    = 8'h12;

  localparam logic [15:0] MATCH_PORT_RST = 16'd20020;
  localparam logic [7:0]  OPT_KIND_RST   = 8'd254;

  localparam logic CFG_MATCH_PORT = 1'b0;
  localparam logic CFG_OPT_KIND   = 1'b1;

  // one output beat plus a byte-wise patch the back end merges in
  typedef struct packed {
    logic [63:0] word;
    logic [63:0] repl;
    logic [7:0]  mask;   // bit j covers byte j, byte 0 in bits 63:56
    logic [3:0]  nbytes;
    logic        last;
    logic        rw;
  } ttr_beat_t;

  // byte s of a 16-byte window, byte 0 in the top bits
  function automatic logic [7:0] pick_byte(input logic [127:0] cat, input logic [3:0] s);
    int base;
    base = 127 - 8 * int'(s);
    return cat[base -: 8];
  endfunction

endpackage

>>> hdl/ttr_queue.sv
// small beat queue between the parser front end and the output back end
// depends on ttr_pkg
module ttr_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  ttr_pkg::ttr_beat_t push_data,
  output logic               full,
  input  logic               pop,
  output ttr_pkg::ttr_beat_t pop_data,
  output logic               empty
);
  import ttr_pkg::*;

  ttr_beat_t         q_mem [Q_DEPTH];
  logic [Q_AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [Q_AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [Q_AW:0]     cnt_r, cnt_nxt;
  logic              do_push, do_pop;

  assign full     = (cnt_r == (Q_AW+1)'(Q_DEPTH));
  assign empty    = (cnt_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = q_mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_mem[wr_ptr_r] <= push_data;
    end
  end

endmodule

>>> hdl/ttr_front.sv
// front end: takes input beats, buffers the header, parses and flushes it, passes the rest
// depends on ttr_pkg; feeds ttr_queue
module ttr_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic               cfg_addr,
  input  logic [15:0]        cfg_wdata,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [63:0]        in_word,
  input  logic [3:0]         in_bytes,
  input  logic               in_last,
  output logic               q_push,
  output ttr_pkg::ttr_beat_t q_data,
  input  logic               q_full
);
  import ttr_pkg::*;

  typedef enum logic [16:0] {
    S_IDLE    = 17'b00000000000000001,
    S_START   = 17'b00000000000000010,
    S_ET      = 17'b00000000000000100,
    S_PROTO   = 17'b00000000000001000,
    S_IHL     = 17'b00000000000010000,
    S_SIP0    = 17'b00000000000100000,
    S_SIP1    = 17'b00000000001000000,
    S_FLAGS   = 17'b00000000010000000,
    S_PORT    = 17'b00000000100000000,
    S_SPORT   = 17'b00000001000000000,
    S_CHK     = 17'b00000010000000000,
    S_WALK    = 17'b00000100000000000,
    S_OPT     = 17'b00001000000000000,
    S_CSUM    = 17'b00010000000000000,
    S_FOLD    = 17'b00100000000000000,
    S_FL_RD   = 17'b01000000000000000,
    S_FL_PUSH = 17'b10000000000000000
  } state_t;

  state_t          state_r, state_nxt;
  logic [15:0]     match_port_r;
  logic [7:0]      opt_kind_r;
  logic [HW_AW:0]  words_r, words_nxt;
  logic            pass_r, pass_nxt;
  logic            rw_r, rw_nxt;
  logic            last_r, last_nxt;
  logic [3:0]      nlast_r, nlast_nxt;
  logic [AVW-1:0]  avail_r, avail_nxt;
  logic [7:0]      need_r, need_nxt;
  logic [7:0]      ip_off_r, ip_off_nxt;
  logic [7:0]      tcp_off_r, tcp_off_nxt;
  logic [3:0]      doff_r, doff_nxt;
  logic [7:0]      off_r, off_nxt;
  logic [5:0]      olen_r, olen_nxt;
  logic [SW-1:0]   step_r, step_nxt;
  logic [7:0]      found_r, found_nxt;
  logic [15:0]     sport_r, sport_nxt;
  logic [31:0]     sip_r, sip_nxt;
  logic [15:0]     chk_r, chk_nxt;
  logic [19:0]     sum_r, sum_nxt;
  logic [7:0]      base_r, base_nxt;
  logic [2:0]      k_r, k_nxt;
  logic [2:0]      nw_r, nw_nxt;
  logic [HW_AW:0]  fk_r, fk_nxt;

  logic [63:0]     mem [HEADER_WORDS];
  logic [63:0]     rd0_q, rd1_q;
  logic [2:0]      sel_r;
  logic [PW-1:0]   rd_p;
  logic [HW_AW-1:0] rd_idx, rd_idx1;
  logic            mem_we;

  logic [7:0]      b0, b1;
  logic [3:0]      n_in;
  logic            acc;

  assign in_ready = (state_r == S_IDLE) && !q_full;
  assign acc      = in_valid && in_ready;
  assign n_in     = (in_bytes == 4'd0 || in_bytes > 4'd8 || !in_last) ? 4'd8 : in_bytes;
  assign b0       = pick_byte({rd0_q, rd1_q}, {1'b0, sel_r});
  assign b1       = pick_byte({rd0_q, rd1_q}, {1'b0, sel_r} + 4'd1);
  assign rd_idx   = rd_p[PW-1:3];
  assign rd_idx1  = rd_idx + 1'b1;

  // replacement byte at frame position p: {hit, value}
  function automatic logic [8:0] patch_byte(input logic [PW-1:0] p);
    logic [PW-1:0] d;
    logic [7:0]    v;
    d = p - PW'(found_r);
    case (d[3:0])
      4'd0:    v = opt_kind_r;
      4'd1:    v = NEW_LEN;
      4'd2:    v = sport_r[15:8];
      4'd3:    v = sport_r[7:0];
      4'd4:    v = sip_r[31:24];
      4'd5:    v = sip_r[23:16];
      4'd6:    v = sip_r[15:8];
      4'd7:    v = sip_r[7:0];
      default: v = OPT_NOP;
    endcase
    return {(d < PW'(TS_LEN)), v};
  endfunction

  always_comb begin
    logic          go_wait;
    logic          go_no;
    logic [AVW-1:0] av_new;
    logic [7:0]    t8;
    logic          odd;
    logic [7:0]    pp;
    logic [8:0]    pb0, pb1;
    logic [15:0]   o16, n16;
    logic [16:0]   s1;
    logic [15:0]   s2;
    logic          fin;
    logic [PW-1:0] pj;
    logic [8:0]    pb;

    state_nxt   = state_r;
    words_nxt   = words_r;
    pass_nxt    = pass_r;
    rw_nxt      = rw_r;
    last_nxt    = last_r;
    nlast_nxt   = nlast_r;
    avail_nxt   = avail_r;
    need_nxt    = need_r;
    ip_off_nxt  = ip_off_r;
    tcp_off_nxt = tcp_off_r;
    doff_nxt    = doff_r;
    off_nxt     = off_r;
    olen_nxt    = olen_r;
    step_nxt    = step_r;
    found_nxt   = found_r;
    sport_nxt   = sport_r;
    sip_nxt     = sip_r;
    chk_nxt     = chk_r;
    sum_nxt     = sum_r;
    base_nxt    = base_r;
    k_nxt       = k_r;
    nw_nxt      = nw_r;
    fk_nxt      = fk_r;
    rd_p        = '0;
    mem_we      = 1'b0;
    q_push      = 1'b0;
    q_data      = '0;
    go_wait     = 1'b0;
    go_no       = 1'b0;
    av_new      = '0;
    t8          = '0;
    odd         = 1'b0;
    pp          = '0;
    pb0         = '0;
    pb1         = '0;
    o16         = '0;
    n16         = '0;
    s1          = '0;
    s2          = '0;
    fin         = 1'b0;
    pj          = '0;
    pb          = '0;

    case (state_r)
      S_IDLE: begin
        if (acc) begin
          if (pass_r) begin
            q_push        = 1'b1;
            q_data.word   = in_word;
            q_data.nbytes = n_in;
            q_data.last   = in_last;
            q_data.rw     = in_last && rw_r;
            if (in_last) begin
              pass_nxt = 1'b0;
              rw_nxt   = 1'b0;
              need_nxt = 8'd14;
            end
          end else begin
            mem_we    = 1'b1;
            words_nxt = words_r + 1'b1;
            av_new    = AVW'({words_r[HW_AW-1:0], 3'b000}) + AVW'(n_in);
            avail_nxt = av_new;
            last_nxt  = in_last;
            nlast_nxt = n_in;
            // skip the parse until enough bytes are in, the frame ends or the buffer fills
            if (in_last || av_new >= AVW'(need_r) ||
                words_r + 1'b1 == (HW_AW+1)'(HEADER_WORDS)) begin
              state_nxt = S_START;
            end
          end
        end
      end
      S_START: begin
        if (avail_r < AVW'(14)) begin
          go_wait = 1'b1;
        end else begin
          rd_p      = PW'(12);
          state_nxt = S_ET;
        end
      end
      S_ET: begin
        t8         = ({b0, b1} == VLAN_TPID) ? 8'd18 : 8'd14;
        ip_off_nxt = t8;
        if (avail_r < AVW'(t8 + 8'd20)) begin
          need_nxt = t8 + 8'd20;
          go_wait  = 1'b1;
        end else begin
          rd_p      = PW'(t8 + 8'd8);
          state_nxt = S_PROTO;
        end
      end
      S_PROTO: begin
        if (b1 != PROTO_TCP) begin
          go_no = 1'b1;
        end else begin
          rd_p      = PW'(ip_off_r);
          state_nxt = S_IHL;
        end
      end
      S_IHL: begin
        t8          = ip_off_r + {2'b00, b0[3:0], 2'b00};
        tcp_off_nxt = t8;
        if (avail_r < AVW'(t8) + AVW'(20)) begin
          need_nxt = t8 + 8'd20;
          go_wait  = 1'b1;
        end else begin
          rd_p      = PW'(ip_off_r + 8'd12);
          state_nxt = S_SIP0;
        end
      end
      S_SIP0: begin
        sip_nxt[31:16] = {b0, b1};
        rd_p           = PW'(ip_off_r + 8'd14);
        state_nxt      = S_SIP1;
      end
      S_SIP1: begin
        sip_nxt[15:0] = {b0, b1};
        rd_p          = PW'(tcp_off_r + 8'd12);
        state_nxt     = S_FLAGS;
      end
      S_FLAGS: begin
        if ((b1 & SYN_ACK) == 8'd0) begin
          go_no = 1'b1;
        end else begin
          doff_nxt  = b0[7:4];
          rd_p      = PW'(tcp_off_r + 8'd2);
          state_nxt = S_PORT;
        end
      end
      S_PORT: begin
        t8 = tcp_off_r + {2'b00, doff_r, 2'b00};
        if ({b0, b1} != match_port_r || doff_r < 4'd5) begin
          go_no = 1'b1;
        end else if (avail_r < AVW'(t8) && !last_r) begin
          need_nxt = t8;
          go_wait  = 1'b1;
        end else begin
          rd_p      = PW'(tcp_off_r);
          state_nxt = S_SPORT;
        end
      end
      S_SPORT: begin
        sport_nxt = {b0, b1};
        rd_p      = PW'(tcp_off_r + 8'd16);
        state_nxt = S_CHK;
      end
      S_CHK: begin
        chk_nxt   = {b0, b1};
        off_nxt   = tcp_off_r + 8'd20;
        olen_nxt  = {doff_r, 2'b00} - 6'd20;
        step_nxt  = '0;
        state_nxt = S_WALK;
      end
      S_WALK: begin
        if (step_r == SW'(MAX_OPTION_STEPS) || olen_r < 6'd2 ||
            AVW'(off_r) + AVW'(2) > avail_r) begin
          go_no = 1'b1;
        end else begin
          rd_p      = PW'(off_r);
          state_nxt = S_OPT;
        end
      end
      S_OPT: begin
        if (b0 == OPT_EOL) begin
          go_no = 1'b1;
        end else if (b0 == OPT_NOP) begin
          off_nxt   = off_r + 8'd1;
          olen_nxt  = olen_r - 6'd1;
          step_nxt  = step_r + 1'b1;
          state_nxt = S_WALK;
        end else if (b1 < 8'd2 || b1 > {2'b00, olen_r}) begin
          go_no = 1'b1;
        end else if (b0 == OPT_TS && b1 == TS_LEN) begin
          found_nxt = off_r;
          if (AVW'(off_r) + AVW'(TS_LEN) > avail_r) begin
            go_no = 1'b1;
          end else begin
            // checksum words are aligned to the tcp header start
            odd       = off_r[0] ^ tcp_off_r[0];
            base_nxt  = off_r - {7'd0, odd};
            nw_nxt    = odd ? 3'd6 : 3'd5;
            sum_nxt   = {4'd0, ~chk_r};
            k_nxt     = '0;
            rd_p      = PW'(off_r - {7'd0, odd});
            state_nxt = S_CSUM;
          end
        end else begin
          off_nxt   = off_r + b1;
          olen_nxt  = olen_r - b1[5:0];
          step_nxt  = step_r + 1'b1;
          state_nxt = S_WALK;
        end
      end
      S_CSUM: begin
        pp  = base_r + {4'd0, k_r, 1'b0};
        pb0 = patch_byte(PW'(pp));
        pb1 = patch_byte(PW'(pp + 8'd1));
        o16 = {b0, b1};
        n16 = {pb0[8] ? pb0[7:0] : b0, pb1[8] ? pb1[7:0] : b1};
        if (o16 != n16) begin
          sum_nxt = sum_r + {4'd0, ~o16} + {4'd0, n16};
        end
        k_nxt = k_r + 3'd1;
        if (k_r + 3'd1 == nw_r) begin
          state_nxt = S_FOLD;
        end else begin
          rd_p = PW'(pp + 8'd2);
        end
      end
      S_FOLD: begin
        s1        = {1'b0, sum_r[15:0]} + {13'd0, sum_r[19:16]};
        s2        = s1[15:0] + {15'd0, s1[16]};
        chk_nxt   = ~s2;
        rw_nxt    = 1'b1;
        fk_nxt    = '0;
        state_nxt = S_FL_RD;
      end
      S_FL_RD: begin
        rd_p      = {fk_r[HW_AW-1:0], 3'b000};
        state_nxt = S_FL_PUSH;
      end
      S_FL_PUSH: begin
        // keep the read window on this word while the queue is full
        rd_p = {fk_r[HW_AW-1:0], 3'b000};
        if (!q_full) begin
          fin           = last_r && (fk_r + 1'b1 == words_r);
          q_push        = 1'b1;
          q_data.word   = rd0_q;
          q_data.nbytes = fin ? nlast_r : 4'd8;
          q_data.last   = fin;
          q_data.rw     = fin && rw_r;
          for (int j = 0; j < 8; j++) begin
            pj = {fk_r[HW_AW-1:0], 3'b000} + PW'(j);
            pb = patch_byte(pj);
            if (rw_r && pb[8]) begin
              q_data.mask[j]           = 1'b1;
              q_data.repl[63-8*j -: 8] = pb[7:0];
            end
            if (rw_r && pj == PW'(tcp_off_r) + PW'(16)) begin
              q_data.mask[j]           = 1'b1;
              q_data.repl[63-8*j -: 8] = chk_r[15:8];
            end
            if (rw_r && pj == PW'(tcp_off_r) + PW'(17)) begin
              q_data.mask[j]           = 1'b1;
              q_data.repl[63-8*j -: 8] = chk_r[7:0];
            end
          end
          fk_nxt = fk_r + 1'b1;
          if (fk_r + 1'b1 == words_r) begin
            words_nxt = '0;
            need_nxt  = 8'd14;
            state_nxt = S_IDLE;
            if (last_r) begin
              pass_nxt = 1'b0;
              rw_nxt   = 1'b0;
            end else begin
              pass_nxt = 1'b1;
            end
          end else begin
            state_nxt = S_FL_RD;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // more bytes needed: wait for the next beat unless the frame ended or the buffer is full
    if (go_wait) begin
      if (last_r || words_r == (HW_AW+1)'(HEADER_WORDS)) begin
        go_no = 1'b1;
      end else begin
        state_nxt = S_IDLE;
      end
    end
    if (go_no) begin
      rw_nxt    = 1'b0;
      fk_nxt    = '0;
      state_nxt = S_FL_RD;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      match_port_r <= MATCH_PORT_RST;
      opt_kind_r   <= OPT_KIND_RST;
      words_r      <= '0;
      pass_r       <= 1'b0;
      rw_r         <= 1'b0;
      need_r       <= 8'd14;
    end else begin
      state_r <= state_nxt;
      words_r <= words_nxt;
      pass_r  <= pass_nxt;
      rw_r    <= rw_nxt;
      need_r  <= need_nxt;
      if (cfg_we) begin
        case (cfg_addr)
          CFG_MATCH_PORT: match_port_r <= cfg_wdata;
          CFG_OPT_KIND:   opt_kind_r   <= cfg_wdata[7:0];
          default:        ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    last_r    <= last_nxt;
    nlast_r   <= nlast_nxt;
    avail_r   <= avail_nxt;
    ip_off_r  <= ip_off_nxt;
    tcp_off_r <= tcp_off_nxt;
    doff_r    <= doff_nxt;
    off_r     <= off_nxt;
    olen_r    <= olen_nxt;
    step_r    <= step_nxt;
    found_r   <= found_nxt;
    sport_r   <= sport_nxt;
    sip_r     <= sip_nxt;
    chk_r     <= chk_nxt;
    sum_r     <= sum_nxt;
    base_r    <= base_nxt;
    k_r       <= k_nxt;
    nw_r      <= nw_nxt;
    fk_r      <= fk_nxt;
  end

  // header buffer, one write port and a two-word read window
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[words_r[HW_AW-1:0]] <= in_word;
    end
    rd0_q <= mem[rd_idx];
    rd1_q <= mem[rd_idx1];
    sel_r <= rd_p[2:0];
  end

endmodule

>>> hdl/ttr_back.sv
// back end: pops queued beats, merges the option patch and holds the output beat
// depends on ttr_pkg; fed by ttr_queue
module ttr_back (
  input  logic               clk,
  input  logic               rst_n,
  input  ttr_pkg::ttr_beat_t q_data,
  input  logic               q_empty,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [63:0]        out_word,
  output logic [3:0]         out_bytes,
  output logic               out_last,
  output logic               out_rw
);
  import ttr_pkg::*;

  logic        vld_r, vld_nxt;
  logic [63:0] word_r;
  logic [3:0]  bytes_r;
  logic        last_r;
  logic        rw_r;
  logic [63:0] mask_w;

  assign q_pop = !q_empty && (!vld_r || out_ready);

  always_comb begin
    for (int j = 0; j < 8; j++) begin
      mask_w[63-8*j -: 8] = {8{q_data.mask[j]}};
    end
  end

  always_comb begin
    vld_nxt = vld_r;
    if (q_pop) begin
      vld_nxt = 1'b1;
    end else if (out_ready) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      word_r  <= (q_data.word & ~mask_w) | (q_data.repl & mask_w);
      bytes_r <= q_data.nbytes;
      last_r  <= q_data.last;
      rw_r    <= q_data.rw;
    end
  end

  assign out_valid = vld_r;
  assign out_word  = word_r;
  assign out_bytes = bytes_r;
  assign out_last  = last_r;
  assign out_rw    = rw_r;

endmodule

>>> hdl/tcp_timestamp_to_toa_rewriter.sv
// tcp timestamp-to-address option rewriter, top level
// pass-through beats are written into the queue, then into the back end output register; header
//   beats leave after the parse and flush. throughput: 1 beat per cycle in pass-through while
//   the queue is not full; the parse (field reads, option steps, checksum words) reruns if more
//   bytes are needed, and the flush reads each word via the single read window, then pushes it
// reset: synchronous active-low rst_n clears control state and restores the config registers
// depends on ttr_pkg, ttr_front, ttr_queue, ttr_back
module tcp_timestamp_to_toa_rewriter (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_addr,
  input  logic [15:0] cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [71:0] in_tdata,   // in_word[63:0], in_bytes[67:64], zero pad
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,  // out_word[63:0], out_bytes[67:64], zero pad
  output logic        out_tlast,
  output logic        out_tuser   // rewritten
);
  import ttr_pkg::*;

  ttr_beat_t   push_data, pop_data;
  logic        q_push, q_full, q_pop, q_empty;
  logic [63:0] o_word;
  logic [3:0]  o_bytes;

  ttr_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_word   (in_tdata[63:0]),
    .in_bytes  (in_tdata[67:64]),
    .in_last   (in_tlast),
    .q_push    (q_push),
    .q_data    (push_data),
    .q_full    (q_full)
  );

  ttr_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (pop_data),
    .empty     (q_empty)
  );

  ttr_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_data    (pop_data),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_word  (o_word),
    .out_bytes (o_bytes),
    .out_last  (out_tlast),
    .out_rw    (out_tuser)
  );

  assign out_tdata = {4'd0, o_bytes, o_word};

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 100ps
// testbench for tcp_timestamp_to_toa_rewriter: drives frames as 64-bit beats, predicts
// the rewritten stream with its own header parser and compares every output beat
// depends on ttr_pkg and the rewriter rtl
module tb;
  import ttr_pkg::*;

  typedef struct packed {
    logic [63:0] word;
    logic [3:0]  nbytes;
    logic        last;
    logic        rw;
  } beat_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic        cfg_addr = CFG_MATCH_PORT;
  logic [15:0] cfg_wdata = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [71:0] in_tdata = '0;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [71:0] out_tdata;
  logic        out_tlast;
  logic        out_tuser;

  tcp_timestamp_to_toa_rewriter u_dut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // predictor state
  logic [63:0] hdr_buf [HEADER_WORDS];
  int          held_words;
  bit          passing;
  bit          frame_rw;
  logic [15:0] port_sel = MATCH_PORT_RST;
  logic [7:0]  kind_sel = OPT_KIND_RST;
  beat_t       expected_beats [$];

  int errors = 0;
  int idle_pct = 22;
  int stall_pct = 22;
  int quiet_cycles = 0;

  task automatic report_mismatch(input string msg);
    $display("mismatch: %s", msg);
    errors++;
  endtask

  function automatic logic [7:0] hbyte(input int p);
    if ((p >> 3) >= HEADER_WORDS) return 8'h00;
    return hdr_buf[p >> 3][63 - 8 * (p & 7) -: 8];
  endfunction

  function automatic void hput(input int p, input logic [7:0] v);
    if ((p >> 3) < HEADER_WORDS) hdr_buf[p >> 3][63 - 8 * (p & 7) -: 8] = v;
  endfunction

  // -1 need more, 0 unchanged, 1 rewritten
  function automatic int parse_header(input int avail, input bit last);
    int ip_off, tcp_off, doff, hdr_end, off, olen, found, base, nw, kind, len;
    logic [7:0] blk [10];
    logic [7:0] old [12];
    logic [15:0] chk, o, n;
    logic [31:0] sum;
    ip_off = 14;
    found = 0;
    if (avail < 14) return last ? 0 : -1;
    if ({hbyte(12), hbyte(13)} == VLAN_TPID) ip_off = 18;
    if (avail < ip_off + 20) return last ? 0 : -1;
    if (hbyte(ip_off + 9) != PROTO_TCP) return 0;
    tcp_off = ip_off + (hbyte(ip_off) & 8'hf) * 4;
    if (avail < tcp_off + 20) return last ? 0 : -1;
    if ((hbyte(tcp_off + 13) & SYN_ACK) == 0) return 0;
    if ({hbyte(tcp_off + 2), hbyte(tcp_off + 3)} != port_sel) return 0;
    doff = hbyte(tcp_off + 12) >> 4;
    if (doff < 5) return 0;
    hdr_end = tcp_off + doff * 4;
    if (avail < hdr_end && !last) return -1;
    off = tcp_off + 20;
    olen = doff * 4 - 20;
    for (int i = 0; i < MAX_OPTION_STEPS; i++) begin
      if (olen < 2 || off + 2 > avail) break;
      kind = hbyte(off);
      if (kind == OPT_EOL) break;
      if (kind == OPT_NOP) begin
        off++;
        olen--;
        continue;
      end
      len = hbyte(off + 1);
      if (len < 2 || len > olen) break;
      if (kind == OPT_TS && len == TS_LEN) begin
        found = off;
        break;
      end
      off += len;
      olen -= len;
    end
    if (found == 0 || found + 10 > avail) return 0;
    blk[0] = kind_sel;
    blk[1] = NEW_LEN;
    blk[2] = hbyte(tcp_off);
    blk[3] = hbyte(tcp_off + 1);
    for (int k = 0; k < 4; k++) blk[4 + k] = hbyte(ip_off + 12 + k);
    blk[8] = OPT_NOP;
    blk[9] = OPT_NOP;
    base = found - ((found - tcp_off) & 1);
    nw = (found + 10 - base + 1) / 2;
    for (int k = 0; k < 2 * nw; k++) old[k] = hbyte(base + k);
    for (int k = 0; k < 10; k++) hput(found + k, blk[k]);
    chk = {hbyte(tcp_off + 16), hbyte(tcp_off + 17)};
    sum = {16'h0, ~chk};
    for (int k = 0; k < nw; k++) begin
      o = {old[2 * k], old[2 * k + 1]};
      n = {hbyte(base + 2 * k), hbyte(base + 2 * k + 1)};
      if (o != n) sum += {16'h0, ~o} + {16'h0, n};
    end
    while (sum >> 16) sum = (sum & 32'hffff) + (sum >> 16);
    chk = ~sum[15:0];
    hput(tcp_off + 16, chk[15:8]);
    hput(tcp_off + 17, chk[7:0]);
    return 1;
  endfunction

  function automatic void predict_beat(input logic [63:0] w, input logic [3:0] nb,
                                       input bit last);
    int n, avail, r;
    n = (nb == 0 || nb > 8 || !last) ? 8 : nb;
    if (passing) begin
      expected_beats.push_back('{w, 4'(n), last, last && frame_rw});
      if (last) begin
        passing = 0;
        frame_rw = 0;
      end
      return;
    end
    if (held_words >= HEADER_WORDS) held_words = 0;
    hdr_buf[held_words] = w;
    held_words++;
    avail = (held_words - 1) * 8 + n;
    r = parse_header(avail, last);
    if (r < 0 && held_words < HEADER_WORDS) return;
    frame_rw = (r > 0);
    for (int k = 0; k < held_words; k++) begin
      expected_beats.push_back('{hdr_buf[k], (last && k + 1 == held_words) ? 4'(n) : 4'd8,
                                 last && k + 1 == held_words,
                                 last && k + 1 == held_words && frame_rw});
    end
    held_words = 0;
    if (last) frame_rw = 0;
    else passing = 1;
  endfunction

  task automatic send_beat(input logic [63:0] w, input logic [3:0] nb, input bit last);
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {4'h0, nb, w};
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_beat(w, nb, last);
    @(negedge clk);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (expected_beats.size() != 0) @(negedge clk);
    repeat (60) @(negedge clk);
  endtask

  task automatic write_reg(input logic addr, input logic [15:0] val);
    drain();
    cfg_we <= 1'b1;
    cfg_addr <= addr;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (addr == CFG_MATCH_PORT) port_sel = val;
    else kind_sel = val[7:0];
  endtask

  // frame builder: bytes then split into beats
  logic [7:0] fb [$];

  task automatic send_frame(input logic [3:0] tail_nb = 0);
    int nwords;
    logic [63:0] w;
    logic [3:0] nb;
    nwords = (fb.size() + 7) / 8;
    if (nwords == 0) nwords = 1;
    for (int i = 0; i < nwords; i++) begin
      w = '0;
      for (int j = 0; j < 8; j++)
        w[63 - 8 * j -: 8] = (i * 8 + j < fb.size()) ? fb[i * 8 + j] : 8'($urandom);
      nb = (fb.size() - i * 8 >= 8) ? 4'd8 : 4'(fb.size() - i * 8);
      if (i == nwords - 1 && tail_nb != 0) nb = tail_nb;
      if (i != nwords - 1 && $urandom_range(9) == 0) nb = 4'($urandom_range(15));
      send_beat(w, nb, i == nwords - 1);
    end
  endtask

  // tcp frame: vlan, ihl, doff, flags, dport, options bytes, payload length
  task automatic build_tcp(input bit vlan, input int ihl, input int doff,
                           input logic [7:0] flags, input logic [15:0] dport,
                           input logic [7:0] opts [$], input int payload);
    fb = {};
    repeat (12) fb.push_back(8'($urandom));
    if (vlan) begin
      fb.push_back(8'h81); fb.push_back(8'h00);
      fb.push_back(8'($urandom)); fb.push_back(8'($urandom));
    end
    fb.push_back(8'h08); fb.push_back(8'h00);
    fb.push_back({4'h4, 4'(ihl)});
    for (int i = 1; i < ihl * 4; i++) fb.push_back(i == 9 ? PROTO_TCP : 8'($urandom));
    for (int i = 0; i < 20; i++) begin
      case (i)
        2: fb.push_back(dport[15:8]);
        3: fb.push_back(dport[7:0]);
        12: fb.push_back({4'(doff), 4'h0});
        13: fb.push_back(flags);
        default: fb.push_back(8'($urandom));
      endcase
    end
    for (int i = 0; i < doff * 4 - 20; i++)
      fb.push_back(i < opts.size() ? opts[i] : OPT_NOP);
    repeat (payload) fb.push_back(8'($urandom));
  endtask

  function automatic void ts_opts(ref logic [7:0] o [$], input int pre_nops);
    o = {};
    repeat (pre_nops) o.push_back(OPT_NOP);
    o.push_back(OPT_TS); o.push_back(TS_LEN);
    repeat (8) o.push_back(8'($urandom));
  endfunction

  task automatic test_directed();
    logic [7:0] o [$];
    ts_opts(o, 2);
    build_tcp(1'b0, 5, 8, SYN_ACK, port_sel, o, 0);
    send_frame();
    ts_opts(o, 1);
    build_tcp(1'b1, 5, 8, 8'h02, port_sel, o, 13);
    send_frame();
    ts_opts(o, 0);
    build_tcp(1'b0, 5, 8, 8'h10, 16'(port_sel + 16'd1), o, 5);
    send_frame();
    build_tcp(1'b0, 5, 8, 8'h01, port_sel, o, 5);
    send_frame();
    build_tcp(1'b0, 4, 8, SYN_ACK, port_sel, o, 3);
    send_frame(4'd0);
    build_tcp(1'b0, 5, 4, SYN_ACK, port_sel, o, 20);
    send_frame(4'd15);
    o = {8'h02, 8'h04, 8'h05, 8'hb4, OPT_TS, TS_LEN};
    build_tcp(1'b0, 5, 10, SYN_ACK, port_sel, o, 0);
    send_frame();
    o = {OPT_EOL, OPT_TS, TS_LEN};
    build_tcp(1'b0, 5, 8, SYN_ACK, port_sel, o, 0);
    send_frame();
    o = {8'h05, 8'h01};
    build_tcp(1'b0, 5, 8, SYN_ACK, port_sel, o, 0);
    send_frame();
    // frame cut inside the option
    ts_opts(o, 0);
    build_tcp(1'b0, 5, 8, SYN_ACK, port_sel, o, 0);
    repeat (5) void'(fb.pop_back());
    send_frame();
    // tiny frames
    send_beat(64'hffff_ffff_ffff_ffff, 4'd1, 1'b1);
    send_beat(64'h0, 4'd8, 1'b0);
    send_beat(64'h0, 4'd8, 1'b1);
    // buffer overflow: 40 full words, no ip
    for (int i = 0; i < 40; i++) send_beat({$urandom, $urandom}, 4'd8, i == 39);
  endtask

  task automatic test_config();
    logic [7:0] o [$];
    logic [15:0] ports [4] = '{16'h0000, 16'hffff, 16'h1234, MATCH_PORT_RST};
    logic [7:0]  kinds [4] = '{8'h00, 8'hff, 8'h5a, OPT_KIND_RST};
    for (int i = 0; i < 4; i++) begin
      write_reg(CFG_MATCH_PORT, ports[i]);
      write_reg(CFG_OPT_KIND, {8'($urandom), kinds[i]});
      ts_opts(o, i);
      build_tcp(i[0], 5, 10, SYN_ACK, ports[i], o, i * 7);
      send_frame();
    end
  endtask

  task automatic test_random(input int nbeats);
    logic [7:0] o [$];
    int sel, start;
    start = 0;
    while (start < nbeats) begin
      sel = $urandom_range(9);
      if (sel < 7) begin
        ts_opts(o, $urandom_range(6));
        if ($urandom_range(4) == 0) o[$urandom_range(o.size() - 1)] = 8'($urandom_range(10));
        build_tcp(1'($urandom_range(1)), $urandom_range(3) == 0 ? $urandom_range(15) : 5,
                  $urandom_range(5, 15), 8'($urandom),
                  $urandom_range(5) == 0 ? 16'($urandom) : port_sel, o,
                  $urandom_range(3) == 0 ? $urandom_range(80) : $urandom_range(12));
        if ($urandom_range(7) == 0) repeat ($urandom_range(30)) void'(fb.pop_back());
      end else begin
        fb = {};
        repeat ($urandom_range(1, 90)) fb.push_back(8'($urandom));
      end
      start += (fb.size() + 7) / 8 + 1;
      send_frame($urandom_range(3) == 0 ? 4'($urandom_range(15)) : 4'd0);
      if ($urandom_range(30) == 0) drain();
    end
  endtask

  // output checker
  always @(posedge clk) begin
    beat_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = '{out_tdata[63:0], out_tdata[67:64], out_tlast, out_tuser};
      if (expected_beats.size() == 0) begin
        report_mismatch($sformatf("unexpected beat %h", got.word));
      end else begin
        want = expected_beats.pop_front();
        if (got.word !== want.word)
          report_mismatch($sformatf("word %h want %h", got.word, want.word));
        if (got.nbytes !== want.nbytes)
          report_mismatch($sformatf("bytes %0d want %0d", got.nbytes, want.nbytes));
        if (got.last !== want.last)
          report_mismatch($sformatf("last %b want %b", got.last, want.last));
        if (got.rw !== want.rw)
          report_mismatch($sformatf("rewritten %b want %b", got.rw, want.rw));
      end
    end
  end

  always @(negedge clk) out_tready <= ($urandom_range(99) >= stall_pct);

  // watchdog on beats moved either way
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 20000) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    held_words = 0;
    passing = 0;
    frame_rw = 0;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_config();
    test_random(90);
    idle_pct = 0;
    stall_pct = 0;
    test_random(30);
    idle_pct = 22;
    stall_pct = 22;
    test_random(90);
    drain();
    if (errors == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
